[rtl/core/mpf_pkg.sv]
// ----------------------------------------------------------------------------
// mpf_pkg
// shared types, codes and constants of the 5x5 missing pixel fill core
// ----------------------------------------------------------------------------
package mpf_pkg;

  localparam int HEIGHT_BITS        = 32;
  localparam int MAX_ROW_LENGTH_DEF = 1024;
  localparam int MAX_ROWS_DEF       = 1024;

  localparam int GEOM_W      = 11;
  localparam int BORDER_W    = 32;
  localparam int MIN_GOOD_W  = 5;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 32;

  localparam int STORE_ROWS = 5;
  localparam int WIN        = 5;
  localparam int CNT_W      = 5;
  localparam int NBR_MAX    = WIN * WIN - 1;

  localparam logic [CFG_INDEX_W-1:0] CFG_ROW_LENGTH = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ROW_COUNT  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_BORDER     = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_MIN_GOOD   = 2'd3;

  localparam logic [1:0] FILL_PASS   = 2'd0;
  localparam logic [1:0] FILL_MEAN   = 2'd1;
  localparam logic [1:0] FILL_BORDER = 2'd2;

  localparam logic [GEOM_W-1:0]     ROW_LENGTH_RST = 11'd1024;
  localparam logic [GEOM_W-1:0]     ROW_COUNT_RST  = 11'd1024;
  localparam logic [MIN_GOOD_W-1:0] MIN_GOOD_RST   = 5'd12;

  typedef struct packed {
    logic                          kind;
    logic signed [HEIGHT_BITS-1:0] height;
    logic                          missing;
  } pix_in_t;

  typedef struct packed {
    logic signed [HEIGHT_BITS-1:0] height_out;
    logic [1:0]                    fill_status;
    logic                          last_pixel;
  } pix_out_t;

  typedef struct packed {
    logic cfg_write;
    logic write_in;
    logic ptr_center;
    logic ptr_first;
    logic ptr_next;
    logic rd;
    logic acc;
    logic set_pass;
    logic set_border;
    logic div_start;
    logic div_step;
    logic set_mean;
    logic finish;
  } mpf_cmd_t;

  typedef struct packed {
    logic in_kind;
    logic draining;
    logic emit_due;
    logic ctr_missing;
    logic ring;
    logic nbr_last;
    logic mean_ok;
    logic div_done;
    logic out_busy;
  } mpf_stat_t;

  function automatic logic [2:0] slot_inc(input logic [2:0] s);
    return (s == 3'd4) ? 3'd0 : s + 3'd1;
  endfunction

endpackage

[rtl/core/missing_pixel_fill_5x5_core.sv]
// ----------------------------------------------------------------------------
// missing_pixel_fill_5x5_core
// fills missing height samples with the mean of their 5x5 neighborhood
// ----------------------------------------------------------------------------
// the result for pixel q is produced once input pixel q + 2*row_length + 2 is taken
// pixels with no result pass through the idle state alone; present or edge pixels
//   take a center read, a check and the hand-off; filled interior pixels add 25
//   window reads and a serial divide over HEIGHT_BITS + 5 quotient bits;
//   no new pixel is taken before the hand-off, which waits on a stalled output
// reset: synchronous, clears counters, output valid and config to defaults;
//   the line store is not cleared
module missing_pixel_fill_5x5_core #(
  parameter int MAX_ROW_LENGTH = mpf_pkg::MAX_ROW_LENGTH_DEF,
  parameter int MAX_ROWS       = mpf_pkg::MAX_ROWS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // pixel input transfers
  input  logic                            in_valid,
  output logic                            in_ready,
  input  mpf_pkg::pix_in_t                in_data,
  // result transfers
  output logic                            out_valid,
  input  logic                            out_ready,
  output mpf_pkg::pix_out_t               out_data,
  // register writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mpf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [mpf_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import mpf_pkg::*;

  // command and status between sequencer and datapath
  mpf_cmd_t  cmd;
  mpf_stat_t stat;

  // sequencer owns both input handshakes
  mpf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // datapath holds the line store and the output register
  mpf_dp #(
    .MAX_ROW_LENGTH (MAX_ROW_LENGTH),
    .MAX_ROWS       (MAX_ROWS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

[rtl/core/mpf_ctrl.sv]
// ----------------------------------------------------------------------------
// mpf_ctrl
// sequencer: input handling, window walk, divide and result hand-off
// ----------------------------------------------------------------------------
module mpf_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  mpf_pkg::mpf_stat_t stat,
  output mpf_pkg::mpf_cmd_t  cmd
);
  import mpf_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b00000001,
    S_CRD    = 8'b00000010,
    S_CCHK   = 8'b00000100,
    S_NRD    = 8'b00001000,
    S_NACC   = 8'b00010000,
    S_DECIDE = 8'b00100000,
    S_DIV    = 8'b01000000,
    S_FIN    = 8'b10000000
  } state_t;

  state_t state, state_next;

  assign in_ready  = (state == S_IDLE) && !rst;
  assign cfg_ready = (state == S_IDLE) && !rst;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        cmd.cfg_write = cfg_valid;
        if (in_valid) begin
          if (stat.draining) begin
            cmd.ptr_center = 1'b1;
            state_next     = S_CRD;
          end else if (!stat.in_kind) begin
            cmd.write_in = 1'b1;
            if (stat.emit_due) begin
              cmd.ptr_center = 1'b1;
              state_next     = S_CRD;
            end
          end
        end
      end
      S_CRD: begin
        cmd.rd     = 1'b1;
        state_next = S_CCHK;
      end
      S_CCHK: begin
        if (!stat.ctr_missing) begin
          cmd.set_pass = 1'b1;
          state_next   = S_FIN;
        end else if (stat.ring) begin
          cmd.set_border = 1'b1;
          state_next     = S_FIN;
        end else begin
          cmd.ptr_first = 1'b1;
          state_next    = S_NRD;
        end
      end
      S_NRD: begin
        cmd.rd     = 1'b1;
        state_next = S_NACC;
      end
      S_NACC: begin
        cmd.acc = 1'b1;
        if (stat.nbr_last) begin
          state_next = S_DECIDE;
        end else begin
          cmd.ptr_next = 1'b1;
          state_next   = S_NRD;
        end
      end
      S_DECIDE: begin
        if (stat.mean_ok) begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end else begin
          cmd.set_border = 1'b1;
          state_next     = S_FIN;
        end
      end
      S_DIV: begin
        if (stat.div_done) begin
          cmd.set_mean = 1'b1;
          state_next   = S_FIN;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_FIN: begin
        if (!stat.out_busy) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[rtl/core/mpf_dp.sv]
// ----------------------------------------------------------------------------
// mpf_dp
// datapath: config, raster counters, line store, window sum, serial divider
// ----------------------------------------------------------------------------
module mpf_dp #(
  parameter int MAX_ROW_LENGTH = mpf_pkg::MAX_ROW_LENGTH_DEF,
  parameter int MAX_ROWS       = mpf_pkg::MAX_ROWS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  mpf_pkg::pix_in_t                    in_data,
  output mpf_pkg::pix_out_t                   out_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  input  logic [mpf_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [mpf_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  mpf_pkg::mpf_cmd_t                   cmd,
  output mpf_pkg::mpf_stat_t                  stat
);
  import mpf_pkg::*;

  localparam int HB    = HEIGHT_BITS;
  localparam int CW    = $clog2(MAX_ROW_LENGTH);
  localparam int LW    = $clog2(MAX_ROW_LENGTH + 1);
  localparam int RW    = $clog2(MAX_ROWS + 1);
  localparam int LCW   = (LW > GEOM_W) ? LW : GEOM_W;
  localparam int RCW   = (RW > GEOM_W) ? RW : GEOM_W;
  localparam int DEPTH = STORE_ROWS * MAX_ROW_LENGTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int CMW   = (HB > BORDER_W) ? HB : BORDER_W;
  localparam int SW    = HB + CNT_W;
  localparam int DCW   = $clog2(SW + 1);

  // config registers
  logic [GEOM_W-1:0]          row_length, row_count;
  logic signed [BORDER_W-1:0] border_value;
  logic [MIN_GOOD_W-1:0]      min_good;

  // raster position
  logic [RW-1:0] in_row, out_row;
  logic [CW-1:0] in_col, out_col;
  logic [2:0]    in_slot, out_slot;

  // window walk and arithmetic
  logic [2:0]           nr, nc;
  logic                 wb;
  logic [HB:0]          rdata;
  logic signed [SW-1:0] acc;
  logic [CNT_W-1:0]     cnt;
  logic [SW-1:0]        dvd;
  logic [CNT_W-1:0]     rem;
  logic                 neg;
  logic [DCW-1:0]       dstep;
  logic [HB-1:0]        res_val;
  logic [1:0]           res_stat;

  logic [HB:0] mem [DEPTH];

  logic [LCW-1:0] rl_x;
  logic [RCW-1:0] rc_x;
  logic [LW-1:0]  len, in_col_inc;
  logic [RW-1:0]  rows;
  logic           in_wrap, out_wrap, last, geom_wr, clr_ctr;
  logic [3:0]     slot_sum;
  logic [2:0]     nbr_slot;
  logic [CW:0]    col_sum;
  logic [CW-1:0]  nbr_col;
  logic [AW-1:0]  rd_addr, in_addr, ctr_addr, wr_addr;
  logic [HB:0]    wr_data;
  logic           we;
  logic signed [CMW-1:0] bval_x, nval_x;
  logic signed [HB-1:0]  rd_val;
  logic [CNT_W:0]        rem_sh;
  logic                  ge;
  logic [SW-1:0]         quo;
  logic                  center;

  assign rl_x = LCW'(row_length);
  assign rc_x = RCW'(row_count);

  always_comb begin
    if (rl_x < LCW'(5)) begin
      len = LW'(5);
    end else if (rl_x > LCW'(MAX_ROW_LENGTH)) begin
      len = LW'(MAX_ROW_LENGTH);
    end else begin
      len = LW'(rl_x);
    end
    if (rc_x < RCW'(5)) begin
      rows = RW'(5);
    end else if (rc_x > RCW'(MAX_ROWS)) begin
      rows = RW'(MAX_ROWS);
    end else begin
      rows = RW'(rc_x);
    end
  end

  assign in_col_inc = LW'(in_col) + LW'(1);
  assign in_wrap    = (in_col_inc >= len);
  assign out_wrap   = ((LW'(out_col) + LW'(1)) >= len);
  assign last       = (out_row == rows - RW'(1)) && (LW'(out_col) == len - LW'(1));

  // window row slot is (out_slot + nr - 2) mod 5
  assign slot_sum = 4'(out_slot) + 4'(nr) + 4'd3;
  always_comb begin
    if (slot_sum >= 4'd10) begin
      nbr_slot = 3'(slot_sum - 4'd10);
    end else if (slot_sum >= 4'd5) begin
      nbr_slot = 3'(slot_sum - 4'd5);
    end else begin
      nbr_slot = 3'(slot_sum);
    end
  end
  assign col_sum = (CW+1)'(out_col) + (CW+1)'(nc) - (CW+1)'(2);
  assign nbr_col = col_sum[CW-1:0];
  assign center  = (nr == 3'd2) && (nc == 3'd2);

  assign rd_addr  = AW'(nbr_slot) * AW'(MAX_ROW_LENGTH) + AW'(nbr_col);
  assign in_addr  = AW'(in_slot) * AW'(MAX_ROW_LENGTH) + AW'(in_col);
  assign ctr_addr = AW'(out_slot) * AW'(MAX_ROW_LENGTH) + AW'(out_col);

  assign we      = cmd.write_in || (cmd.finish && wb);
  assign wr_addr = cmd.write_in ? in_addr : ctr_addr;
  assign wr_data = cmd.write_in ? {in_data.missing, in_data.height} : {1'b0, res_val};

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd) begin
      rdata <= mem[rd_addr];
    end
  end

  assign rd_val = rdata[HB-1:0];
  assign bval_x = CMW'(border_value);
  assign nval_x = CMW'(rd_val);

  // config
  always_ff @(posedge clk) begin
    if (rst) begin
      row_length   <= ROW_LENGTH_RST;
      row_count    <= ROW_COUNT_RST;
      border_value <= '0;
      min_good     <= MIN_GOOD_RST;
    end else if (cmd.cfg_write) begin
      case (cfg_index)
        CFG_ROW_LENGTH: row_length   <= cfg_data[GEOM_W-1:0];
        CFG_ROW_COUNT:  row_count    <= cfg_data[GEOM_W-1:0];
        CFG_BORDER:     border_value <= cfg_data[BORDER_W-1:0];
        CFG_MIN_GOOD:   min_good     <= cfg_data[MIN_GOOD_W-1:0];
        default:        ;
      endcase
    end
  end

  assign geom_wr = cmd.cfg_write &&
                   ((cfg_index == CFG_ROW_LENGTH) || (cfg_index == CFG_ROW_COUNT));
  assign clr_ctr = geom_wr || (cmd.finish && last);

  // raster counters
  always_ff @(posedge clk) begin
    if (rst || clr_ctr) begin
      in_row   <= '0;
      in_col   <= '0;
      in_slot  <= '0;
      out_row  <= '0;
      out_col  <= '0;
      out_slot <= '0;
    end else begin
      if (cmd.write_in) begin
        if (in_wrap) begin
          in_col  <= '0;
          in_row  <= in_row + RW'(1);
          in_slot <= slot_inc(in_slot);
        end else begin
          in_col <= in_col + CW'(1);
        end
      end
      if (cmd.finish) begin
        if (out_wrap) begin
          out_col  <= '0;
          out_row  <= out_row + RW'(1);
          out_slot <= slot_inc(out_slot);
        end else begin
          out_col <= out_col + CW'(1);
        end
      end
    end
  end

  // window pointer, sum and count
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.ptr_first) begin
      cnt <= '0;
    end else if (cmd.acc && !center && !rdata[HB] && (nval_x > bval_x)) begin
      cnt <= cnt + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ptr_center) begin
      nr <= 3'd2;
      nc <= 3'd2;
      wb <= 1'b0;
    end else if (cmd.ptr_first) begin
      nr  <= 3'd0;
      nc  <= 3'd0;
      wb  <= 1'b1;
      acc <= '0;
    end else if (cmd.ptr_next) begin
      if (nc == 3'(WIN - 1)) begin
        nc <= 3'd0;
        nr <= nr + 3'd1;
      end else begin
        nc <= nc + 3'd1;
      end
    end
    if (cmd.acc && !center && !rdata[HB] && (nval_x > bval_x)) begin
      acc <= acc + SW'(rd_val);
    end
  end

  // restoring divider, one quotient bit a cycle on magnitudes
  assign rem_sh = {rem, dvd[SW-1]};
  assign ge     = (rem_sh >= (CNT_W+1)'(cnt));
  assign quo    = neg ? (SW'(0) - dvd) : dvd;

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      neg   <= acc[SW-1];
      dvd   <= acc[SW-1] ? (SW'(0) - SW'(acc)) : SW'(acc);
      rem   <= '0;
      dstep <= '0;
    end else if (cmd.div_step) begin
      rem   <= ge ? CNT_W'(rem_sh - (CNT_W+1)'(cnt)) : CNT_W'(rem_sh);
      dvd   <= {dvd[SW-2:0], ge};
      dstep <= dstep + DCW'(1);
    end
  end

  // result select
  always_ff @(posedge clk) begin
    if (cmd.set_pass) begin
      res_val  <= rd_val;
      res_stat <= FILL_PASS;
    end else if (cmd.set_border) begin
      res_val  <= bval_x[HB-1:0];
      res_stat <= FILL_BORDER;
    end else if (cmd.set_mean) begin
      res_val  <= quo[HB-1:0];
      res_stat <= FILL_MEAN;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_data.height_out  <= res_val;
      out_data.fill_status <= res_stat;
      out_data.last_pixel  <= last;
    end
  end

  assign stat.in_kind     = in_data.kind;
  assign stat.draining    = (in_row >= rows);
  assign stat.emit_due    = (in_row >= RW'(3)) || ((in_row == RW'(2)) && (in_col >= CW'(2)));
  assign stat.ctr_missing = rdata[HB];
  assign stat.ring        = (out_row < RW'(2)) || (out_col < CW'(2)) ||
                            (out_row >= rows - RW'(2)) || (LW'(out_col) >= len - LW'(2));
  assign stat.nbr_last    = (nr == 3'(WIN - 1)) && (nc == 3'(WIN - 1));
  assign stat.mean_ok     = (cnt != '0) && (cnt >= min_good);
  assign stat.div_done    = (dstep == DCW'(SW));
  assign stat.out_busy    = out_valid && !out_ready;

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(NBR_MAX))
    else $error("neighbor count above window size");

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |-> (cnt != '0))
    else $error("divide step with zero count");

  a_no_wr_clash: assert property (@(posedge clk) disable iff (rst)
    !(cmd.write_in && cmd.finish))
    else $error("input write and result write in one cycle");

endmodule

[verif/missing_pixel_fill_5x5_core_tb.sv]
// ----------------------------------------------------------------------------
// missing_pixel_fill_5x5_core_tb
// self-checking bench: small raster images go in with random holes and gaps,
// a bit-true fill predictor builds the expected output stream, and each
// output transfer is compared field by field in order of arrival
// ----------------------------------------------------------------------------
module missing_pixel_fill_5x5_core_tb;
  import mpf_pkg::*;

  localparam int STORE_LEN   = STORE_ROWS * MAX_ROW_LENGTH_DEF;
  localparam int SETTLE      = 300;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int ITEM_TARGET = 1050;

  logic                   clk;
  logic                   rst;
  logic                   in_valid;
  logic                   in_ready;
  pix_in_t                in_data;
  logic                   out_valid;
  logic                   out_ready;
  pix_out_t               out_data;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  missing_pixel_fill_5x5_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // clock, period 20
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // fill predictor state: its own line store, raster counters and registers
  // ---------------------------------------------------------------------------
  logic signed [HEIGHT_BITS-1:0] fill_h [STORE_LEN];
  bit                            fill_m [STORE_LEN];
  int                            in_r, in_c, out_r, out_c;
  logic [GEOM_W-1:0]             reg_len, reg_rows;
  logic signed [BORDER_W-1:0]    reg_border;
  logic [MIN_GOOD_W-1:0]         reg_min_good;

  pix_out_t expected_px[$];
  int       fails;
  int       items_sent;
  bit       no_idle;        // stretch with no input gaps
  int       hold_off;       // pressure: receiver holds off this many cycles
  longint   cycles;

  function automatic int geom_len();
    if (reg_len < 5) return 5;
    if (reg_len > MAX_ROW_LENGTH_DEF) return MAX_ROW_LENGTH_DEF;
    return int'(reg_len);
  endfunction

  function automatic int geom_rows();
    if (reg_rows < 5) return 5;
    if (reg_rows > MAX_ROWS_DEF) return MAX_ROWS_DEF;
    return int'(reg_rows);
  endfunction

  function automatic int store_addr(int r, int c);
    return (r % STORE_ROWS) * MAX_ROW_LENGTH_DEF + (c % MAX_ROW_LENGTH_DEF);
  endfunction

  // result for the pixel at the output position, then step the output raster
  function automatic void emit_pixel();
    int len, rows, a, b, cnt;
    longint sum;
    pix_out_t res;
    len  = geom_len();
    rows = geom_rows();
    a    = store_addr(out_r, out_c);
    sum  = 0;
    cnt  = 0;
    if (!fill_m[a]) begin
      res.height_out  = fill_h[a];
      res.fill_status = FILL_PASS;
    end else if (out_r < 2 || out_c < 2 || out_r >= rows - 2 || out_c >= len - 2) begin
      // edge ring: border value, stays missing for later windows
      res.height_out  = reg_border;
      res.fill_status = FILL_BORDER;
    end else begin
      for (int dr = -2; dr <= 2; dr++) begin
        for (int dc = -2; dc <= 2; dc++) begin
          if (dr != 0 || dc != 0) begin
            b = store_addr(out_r + dr, out_c + dc);
            if (!fill_m[b] && fill_h[b] > reg_border) begin
              sum += longint'(fill_h[b]);
              cnt++;
            end
          end
        end
      end
      if (cnt > 0 && cnt >= int'(reg_min_good)) begin
        res.height_out  = HEIGHT_BITS'(sum / cnt);
        res.fill_status = FILL_MEAN;
      end else begin
        res.height_out  = reg_border;
        res.fill_status = FILL_BORDER;
      end
      // filled value feeds the windows of later pixels
      fill_h[a] = res.height_out;
      fill_m[a] = 1'b0;
    end
    res.last_pixel = (out_r == rows - 1 && out_c == len - 1);
    expected_px.push_back(res);
    if (res.last_pixel) begin
      in_r = 0; in_c = 0; out_r = 0; out_c = 0;
    end else if (out_c + 1 >= len) begin
      out_c = 0;
      out_r++;
    end else begin
      out_c++;
    end
  endfunction

  function automatic void predict_input(pix_in_t it);
    int len, a;
    longint p;
    len = geom_len();
    if (in_r >= geom_rows()) begin
      // image fully in: anything drains one result
      emit_pixel();
      return;
    end
    if (it.kind) return;
    a = store_addr(in_r, in_c);
    p = longint'(in_r) * len + in_c;
    fill_h[a] = it.height;
    fill_m[a] = it.missing;
    if (in_c + 1 >= len) begin
      in_c = 0;
      in_r++;
    end else begin
      in_c++;
    end
    if (p >= 2 * len + 2) emit_pixel();
  endfunction

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(15, 60);
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic send_item(pix_in_t it);
    int gap;
    gap = no_idle ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_input(it);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_pixel(logic signed [HEIGHT_BITS-1:0] h, bit miss);
    pix_in_t it;
    it.kind    = 1'b0;
    it.height  = h;
    it.missing = miss;
    send_item(it);
  endtask

  task automatic send_flush();
    pix_in_t it;
    it.kind    = 1'b1;
    it.height  = $urandom;
    it.missing = $urandom_range(0, 1);
    send_item(it);
  endtask

  // drain the rest of the image; now and then a stray pixel does the draining
  task automatic drain_image();
    while (in_r >= geom_rows()) begin
      if ($urandom_range(0, 4) == 0) send_pixel($urandom, $urandom_range(0, 1));
      else send_flush();
    end
  endtask

  // wait for every result, then let any result-free work finish
  task automatic wait_idle();
    in_valid = 1'b0;
    while (expected_px.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_ROW_LENGTH: begin
        reg_len = val[GEOM_W-1:0];
        in_r = 0; in_c = 0; out_r = 0; out_c = 0;
      end
      CFG_ROW_COUNT: begin
        reg_rows = val[GEOM_W-1:0];
        in_r = 0; in_c = 0; out_r = 0; out_c = 0;
      end
      CFG_BORDER:   reg_border   = val;
      CFG_MIN_GOOD: reg_min_good = val[MIN_GOOD_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_image(int len, int rows, logic [31:0] border, int min_good);
    write_reg(CFG_ROW_LENGTH, len);
    write_reg(CFG_ROW_COUNT, rows);
    write_reg(CFG_BORDER, border);
    write_reg(CFG_MIN_GOOD, min_good);
  endtask

  // height mix: full range, values near the border, extremes
  function automatic logic signed [HEIGHT_BITS-1:0] pick_height();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 3) return $urandom;
    if (roll < 8) return reg_border + $signed($urandom_range(0, 2000)) - 300;
    if (roll < 9) return 32'sh7fffffff - $urandom_range(0, 3);
    return 32'sh80000000 + $urandom_range(0, 3);
  endfunction

  // one whole random image, with a few ignored flush ticks mixed in
  task automatic random_image(int miss_pct);
    int len, rows;
    len  = geom_len();
    rows = geom_rows();
    for (int i = 0; i < len * rows; i++) begin
      if ($urandom_range(0, 29) == 0 && i < 2 * len + 2) send_flush();
      send_pixel(pick_height(), $urandom_range(0, 99) < miss_pct);
    end
    drain_image();
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // 5x5: one interior pixel; extremes of height, ring holes, early flush
  task automatic test_directed();
    set_image(5, 5, 32'h0000_0000, 12);
    send_flush();                          // flush before image is in: no result
    for (int i = 0; i < 25; i++) begin
      case (i)
        0:  send_pixel(32'sh7fffffff, 1'b0);
        1:  send_pixel(32'sh80000000, 1'b0);
        3:  send_pixel(32'sh12345678, 1'b1);   // ring hole
        12: send_pixel(32'sh0, 1'b1);          // interior hole, mean
        24: send_pixel(32'sh7fffffff, 1'b1);
        default: send_pixel(32'sh0001_0000 * i, 1'b0);
      endcase
    end
    drain_image();
    wait_idle();
  endtask

  // zero counted neighbors with min_good zero, min_good above 24, and min_good 24 with one good neighbor
  task automatic test_fallbacks();
    set_image(5, 5, 32'sh7fffff00, 0);
    for (int i = 0; i < 25; i++) send_pixel(32'sh100, i == 12);
    drain_image();
    wait_idle();
    set_image(5, 5, 32'h8000_0000, 31);
    for (int i = 0; i < 25; i++) send_pixel(32'sh7fffffff, i == 12);
    drain_image();
    wait_idle();
    write_reg(CFG_MIN_GOOD, 24);
    for (int i = 0; i < 25; i++) send_pixel(-32'sd5, i != 0 || i == 12);
    drain_image();
    wait_idle();
  endtask

  // geometry extremes: clamp below and above, partial images abandoned
  task automatic test_geometry();
    set_image(0, 3, 32'sh0, 12);           // both clamp to 5
    random_image(40);
    wait_idle();
    write_reg(CFG_ROW_LENGTH, 2047);       // clamps to the widest row
    write_reg(CFG_ROW_COUNT, 5);
    for (int i = 0; i < 40; i++) send_pixel($urandom, $urandom_range(0, 1));
    wait_idle();
    write_reg(CFG_ROW_LENGTH, 5);          // abandon and restart
    write_reg(CFG_ROW_COUNT, 2047);
    for (int i = 0; i < 30; i++) send_pixel(pick_height(), $urandom_range(0, 3) == 0);
    wait_idle();
    write_reg(CFG_ROW_COUNT, 6);
    random_image(30);
    wait_idle();
  endtask

  // receiver holds off while the sender keeps offering pixels
  task automatic test_backpressure();
    set_image(8, 6, 32'shffff0000, 6);
    no_idle  = 1'b1;
    hold_off = 600;
    random_image(35);
    no_idle  = 1'b0;
    wait_idle();
  endtask

  task automatic test_random();
    while (items_sent < ITEM_TARGET) begin
      set_image($urandom_range(5, 12), $urandom_range(5, 9), $urandom,
                $urandom_range(0, 3) == 0 ? $urandom_range(0, 31) : $urandom_range(0, 12));
      if ($urandom_range(0, 2) == 0) write_reg(CFG_BORDER, 32'h8000_0000);
      no_idle = ($urandom_range(0, 3) == 0);
      random_image($urandom_range(5, 70));
      no_idle = 1'b0;
      wait_idle();
    end
  endtask

  // ---------------------------------------------------------------------------
  // receiver: random stalls, plus the long hold-off asked by a test
  // ---------------------------------------------------------------------------
  initial begin
    int stall;
    out_ready = 1'b0;
    stall     = 0;
    forever begin
      @(negedge clk);
      if (hold_off > 0) begin
        out_ready = 1'b0;
        hold_off--;
      end else if (stall > 0) begin
        out_ready = 1'b0;
        stall--;
      end else begin
        out_ready = 1'b1;
        stall = pick_gap();
      end
    end
  end

  // ---------------------------------------------------------------------------
  // checker: every output transfer against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    pix_out_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_px.size() == 0) begin
        fails++;
        if (fails <= 10) $display("unexpected result %h", out_data);
      end else begin
        want = expected_px.pop_front();
        if (out_data.height_out !== want.height_out ||
            out_data.fill_status !== want.fill_status ||
            out_data.last_pixel !== want.last_pixel) begin
          fails++;
          if (fails <= 10)
            $display("result: expected h=%h st=%0d last=%0d, got h=%h st=%0d last=%0d",
                     want.height_out, want.fill_status, want.last_pixel,
                     out_data.height_out, out_data.fill_status, out_data.last_pixel);
        end
      end
    end
  end

  // runaway guard
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("missing_pixel_fill_5x5_core: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst          = 1'b1;
    in_valid     = 1'b0;
    in_data      = '0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    fails        = 0;
    items_sent   = 0;
    no_idle      = 1'b0;
    hold_off     = 0;
    cycles       = 0;
    reg_len      = ROW_LENGTH_RST;
    reg_rows     = ROW_COUNT_RST;
    reg_border   = '0;
    reg_min_good = MIN_GOOD_RST;
    in_r = 0; in_c = 0; out_r = 0; out_c = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_fallbacks();
    test_geometry();
    test_backpressure();
    test_random();

    wait_idle();
    if (fails == 0 && expected_px.size() == 0) begin
      $display("missing_pixel_fill_5x5_core: match");
    end else begin
      $display("missing_pixel_fill_5x5_core: mismatch");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/mpf_pkg.sv
rtl/core/mpf_ctrl.sv
rtl/core/mpf_dp.sv
rtl/core/missing_pixel_fill_5x5_core.sv
verif/missing_pixel_fill_5x5_core_tb.sv
